### rtl/core/mmnf_pkg.sv
// Package for the min-max normalize frame block.
// Holds sizing constants, request codes, payload structs and the control state type.
// No dependencies.
package mmnf_pkg;

	// Frame store depth and sample width.
	localparam int MAX_PIXELS  = 4096;
	localparam int SAMPLE_BITS = 32;
	localparam int ADDR_W      = $clog2(MAX_PIXELS);
	localparam int CNT_W       = ADDR_W + 1;

	// Output grey level width and the divider step counter width.
	localparam int PIX_W  = 8;
	localparam int STEP_W = $clog2(PIX_W + 1);

	// Request codes.
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EMIT = 1'b1;

	// One request transaction.
	typedef struct packed {
		logic               req_type;
		logic signed [31:0] sample_value;
		logic               last_sample;
	} req_t;

	// One result transaction.
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last_pixel;
		logic             flat_frame;
	} res_t;

	// Status returned by the serial divider.
	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] quo;
	} div_res_t;

	// Control sequence of one emit request.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_START,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

### rtl/core/mmnf_div.sv
// Serial restoring divider: floor(num * 255 / den), one quotient bit per cycle.
// Depends on mmnf_pkg. Requires num <= den so that the quotient fits in PIX_W bits.
module mmnf_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [mmnf_pkg::SAMPLE_BITS-1:0] num,
	input  logic [mmnf_pkg::SAMPLE_BITS-1:0] den,
	output mmnf_pkg::div_res_t             res
);
	import mmnf_pkg::*;

	logic [SAMPLE_BITS+PIX_W-1:0] prod;
	logic [SAMPLE_BITS-1:0]       rem_q;
	logic [SAMPLE_BITS-1:0]       den_q;
	logic [PIX_W-1:0]             low_q;
	logic [PIX_W-1:0]             quo_q;
	logic [STEP_W-1:0]            step_q;
	logic                         done_q;
	logic [SAMPLE_BITS:0]         trial;
	logic [SAMPLE_BITS+1:0]       diff;
	logic                         ge;

	// The dividend num * 255 is formed as num * 256 - num.
	assign prod = {num, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, num};

	// One trial subtraction per step; no borrow means the quotient bit is one.
	assign trial = {rem_q, low_q[PIX_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = ~diff[SAMPLE_BITS+1];

	// Step counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= STEP_W'(PIX_W);
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == STEP_W'(1));
			if (step_q != '0) begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	// Partial remainder and the shift registers for dividend and quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= prod[SAMPLE_BITS+PIX_W-1:PIX_W];
			low_q <= prod[PIX_W-1:0];
			den_q <= den;
		end else if (step_q != '0) begin
			rem_q <= ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
			low_q <= {low_q[PIX_W-2:0], 1'b0};
			quo_q <= {quo_q[PIX_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quo  = quo_q;

endmodule

### rtl/core/min_max_normalize_frame_top.sv
// Top level of the min-max normalize frame block.
// Depends on mmnf_pkg and mmnf_div.
//
// Usage: the req channel carries load and emit transactions, the res channel
// carries normalized pixels, both with valid/ready handshakes.
// A load stores one signed sample into the 4096-entry frame store and updates
// the running minimum and maximum; it gives no result.
// A load marked last closes the frame, and the next load starts a new frame.
// Loads beyond 4096 samples are dropped, but their last mark still closes the frame.
// An emit on a closed frame reads the next stored sample and returns
// floor((x - min) * 255 / (max - min)) with a last-pixel mark; a flat frame
// gives pixel 0 and the flat_frame flag. An emit on an open frame, or past the
// final sample, gives no result.
// A valid emit goes through these steps before res_valid: the store is read at
// the accepting edge, then the difference terms are registered, the divider
// is loaded, the serial divider forms the eight quotient bits one at a time,
// and the result enters the output register. The next request is accepted in
// the first cycle the result is offered, so a result may wait while it runs.
// If the receiver stalls, a second result waits in the divider until the output
// register is free. Reset clears the frame state; the store needs no clearing.
module min_max_normalize_frame_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mmnf_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_ready,
	output mmnf_pkg::res_t res
);
	import mmnf_pkg::*;

	logic [SAMPLE_BITS-1:0] frame_store_q [MAX_PIXELS];
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SAMPLE_BITS-1:0] num_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [CNT_W-1:0]       stored_count_q;
	logic [CNT_W-1:0]       read_index_q;
	logic [CNT_W-1:0]       cnt_eff;
	logic [CNT_W-1:0]       read_index_inc;
	logic                   frame_closed_q;
	logic                   last_q;
	logic                   flat_q;
	logic                   res_valid_q;
	res_t                   res_q;
	state_t                 state_q;
	state_t                 state_d;
	logic [SAMPLE_BITS-1:0] smp;
	logic                   accept;
	logic                   load_acc;
	logic                   emit_acc;
	logic                   emit_ok;
	logic                   store_ok;
	logic                   div_start;
	logic                   out_load;
	logic                   out_free;
	div_res_t               div_res;

	// Offset-binary sample so that unsigned order follows signed order.
	assign smp = {~req.sample_value[SAMPLE_BITS-1], req.sample_value[SAMPLE_BITS-2:0]};

	assign accept         = req_valid && req_ready;
	assign load_acc       = accept && (req.req_type == REQ_LOAD);
	assign emit_ok        = frame_closed_q && (read_index_q < stored_count_q);
	assign emit_acc       = accept && (req.req_type == REQ_EMIT) && emit_ok;
	assign cnt_eff        = frame_closed_q ? '0 : stored_count_q;
	assign store_ok       = cnt_eff < CNT_W'(MAX_PIXELS);
	assign read_index_inc = read_index_q + CNT_W'(1);
	assign out_free       = !res_valid_q || res_ready;

	// Next state and control outputs.
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (emit_acc) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_START;
			end
			ST_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_res.done) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Frame bookkeeping: counts, extremes and the closed flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count_q <= '0;
			read_index_q   <= '0;
			frame_closed_q <= 1'b0;
			min_q          <= '0;
			max_q          <= '0;
		end else if (load_acc) begin
			frame_closed_q <= req.last_sample;
			read_index_q   <= frame_closed_q ? '0 : read_index_q;
			stored_count_q <= store_ok ? cnt_eff + CNT_W'(1) : cnt_eff;
			if (store_ok) begin
				if (cnt_eff == '0) begin
					min_q <= smp;
					max_q <= smp;
				end else begin
					if (smp < min_q) begin
						min_q <= smp;
					end
					if (smp > max_q) begin
						max_q <= smp;
					end
				end
			end
		end else if (emit_acc) begin
			read_index_q <= read_index_inc;
		end
	end

	// Frame store write port.
	always_ff @(posedge clk) begin
		if (load_acc && store_ok) begin
			frame_store_q[cnt_eff[ADDR_W-1:0]] <= smp;
		end
	end

	// Frame store read port with registered data.
	always_ff @(posedge clk) begin
		if (emit_acc) begin
			rd_data_q <= frame_store_q[read_index_q[ADDR_W-1:0]];
		end
	end

	// Per-pixel flags captured at acceptance, difference terms in the cycle after.
	always_ff @(posedge clk) begin
		if (emit_acc) begin
			last_q <= (read_index_inc == stored_count_q);
			flat_q <= (max_q == min_q);
		end
		if (state_q == ST_READ) begin
			num_q <= rd_data_q - min_q;
			den_q <= max_q - min_q;
		end
	end

	mmnf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.res    (div_res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.pixel      <= flat_q ? '0 : div_res.quo;
			res_q.last_pixel <= last_q;
			res_q.flat_frame <= flat_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The read position never passes the number of stored samples.
	a_read_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		read_index_q <= stored_count_q)
		else $error("read index beyond stored count");

	// The fill count never exceeds the store depth.
	a_count_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		stored_count_q <= CNT_W'(MAX_PIXELS))
		else $error("stored count beyond store depth");

	// The divider finishes only while the sequencer waits for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == ST_DIV)
		else $error("divider finished outside its wait state");

	// A new result appears only after a division has completed.
	a_res_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == ST_DIV || $past(state_q) == ST_DONE))
		else $error("result raised without a completed division");

	// A flat frame always yields a zero pixel.
	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.flat_frame) |-> res_q.pixel == '0)
		else $error("flat frame with nonzero pixel");

endmodule
